// File: src/ioj_pkg.sv
// ----------------------------------------------------------------------------
// ioj_pkg
// Shared constants and types of the interval overlap join.
// ----------------------------------------------------------------------------
`default_nettype none

package ioj_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 16;
    localparam int DEFAULT_INDEX_BITS   = 24;
    localparam int POS_BITS             = 32;
    localparam int RESULT_LIMIT         = 16;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // keep: entry survives pruning; overlap: entry and probe share a position
    typedef struct packed {
        logic keep;
        logic overlap;
    } cmp_res_t;

endpackage

`default_nettype wire

// File: src/ioj_if.sv
// ----------------------------------------------------------------------------
// ioj_in_if / ioj_out_if
// Valid/ready channels for intervals in and overlap pairs out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ioj_in_if #(
    parameter int IDX_W = ioj_pkg::DEFAULT_INDEX_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         job_start;
    logic                         from_first_set;
    logic [ioj_pkg::POS_BITS-1:0] interval_start;
    logic [ioj_pkg::POS_BITS-1:0] interval_stop;
    logic [IDX_W-1:0]             interval_index;

    modport source (
        output valid, job_start, from_first_set, interval_start, interval_stop,
               interval_index,
        input  ready
    );
    modport sink (
        input  valid, job_start, from_first_set, interval_start, interval_stop,
               interval_index,
        output ready
    );
endinterface

interface ioj_out_if #(
    parameter int IDX_W = ioj_pkg::DEFAULT_INDEX_BITS
);
    logic             valid;
    logic             ready;
    logic             pair_valid;
    logic [IDX_W-1:0] first_set_index;
    logic [IDX_W-1:0] second_set_index;
    logic             window_overflow;
    logic             last_result;

    modport source (
        output valid, pair_valid, first_set_index, second_set_index, window_overflow,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, pair_valid, first_set_index, second_set_index, window_overflow,
               last_result,
        output ready
    );
endinterface

`default_nettype wire

// File: src/ioj_ram.sv
// ----------------------------------------------------------------------------
// ioj_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ioj_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/ioj_overlap_unit.sv
// ----------------------------------------------------------------------------
// ioj_overlap_unit
// Compares one window entry against the current interval: prune and overlap.
// ----------------------------------------------------------------------------
`default_nettype none

module ioj_overlap_unit (
    input  wire logic [ioj_pkg::POS_BITS-1:0] entry_start,
    input  wire logic [ioj_pkg::POS_BITS-1:0] entry_stop,
    input  wire logic [ioj_pkg::POS_BITS-1:0] probe_start,
    input  wire logic [ioj_pkg::POS_BITS-1:0] probe_stop,
    output ioj_pkg::cmp_res_t                 res
);

    // min(stops) >= max(starts), unsigned
    always_comb
    begin
        res.keep    = entry_stop >= probe_start;
        res.overlap = (entry_stop >= entry_start) && (entry_stop >= probe_start) &&
                      (probe_stop >= entry_start) && (probe_stop >= probe_start);
    end

endmodule

`default_nettype wire

// File: src/interval_overlap_join_top.sv
// ----------------------------------------------------------------------------
// interval_overlap_join_top
// Sweep-line overlap join of two interval sets with one window per set.
//
//   channel    dir  transaction
//   intervals  in   job_start, from_first_set, interval_start/stop, index
//   pairs      out  pair_valid, first/second_set_index, overflow, last_result
//
// One transaction in runs accept, scan and last result; L = entries in the other window
// (0 to WINDOW_DEPTH): accept in IDLE, one window entry per cycle through the shared
// compare unit with registered RAM read while not stalled, then FLUSH for the last result.
// Output back-pressure stalls the scan whenever a held pair must leave while
// the output register is still full, and holds the last cycle the same way.
// Reset clears the window counts; window RAM contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_overlap_join_top #(
    parameter int WINDOW_DEPTH = ioj_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int INDEX_BITS   = ioj_pkg::DEFAULT_INDEX_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ioj_in_if.sink    intervals,
    ioj_out_if.source pairs
);

    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W  = $clog2(WINDOW_DEPTH);
    localparam int PB      = ioj_pkg::POS_BITS;
    localparam int ENTRY_W = 2 * PB + INDEX_BITS;
    localparam int N_W     = $clog2(ioj_pkg::RESULT_LIMIT + 1);

    ioj_pkg::state_t state_reg, state_next;

    logic                  first_reg, first_next;
    logic [PB-1:0]         st_reg, st_next;
    logic [PB-1:0]         sp_reg, sp_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [CNT_W-1:0]      r_reg, r_next;
    logic [CNT_W-1:0]      w_reg, w_next;
    logic [N_W-1:0]        n_reg, n_next;
    logic                  held_valid_reg, held_valid_next;
    logic [INDEX_BITS-1:0] held_one_reg, held_one_next;
    logic [INDEX_BITS-1:0] held_two_reg, held_two_next;
    logic [CNT_W-1:0]      cnt_one_reg, cnt_one_next;
    logic [CNT_W-1:0]      cnt_two_reg, cnt_two_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_pair_reg, out_pair_next;
    logic [INDEX_BITS-1:0] out_one_reg, out_one_next;
    logic [INDEX_BITS-1:0] out_two_reg, out_two_next;
    logic                  out_ovf_reg, out_ovf_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  out_free;
    logic [CNT_W-1:0]      mc_eff;
    logic [CNT_W-1:0]      oc_eff;
    logic                  app_ok;
    logic [ENTRY_W-1:0]    rd_one;
    logic [ENTRY_W-1:0]    rd_two;
    logic [ENTRY_W-1:0]    entry;
    logic [PB-1:0]         ent_start;
    logic [PB-1:0]         ent_stop;
    logic [INDEX_BITS-1:0] ent_idx;
    ioj_pkg::cmp_res_t     cmp;
    logic                  hit;
    logic                  scan_stall;
    logic                  advance;
    logic [CNT_W-1:0]      r_inc;
    logic                  last_entry;
    logic [ADDR_W-1:0]     raddr;
    logic [ENTRY_W-1:0]    app_data;
    logic                  we_one;
    logic                  we_two;
    logic [ADDR_W-1:0]     waddr_one;
    logic [ADDR_W-1:0]     waddr_two;
    logic [ENTRY_W-1:0]    wdata_one;
    logic [ENTRY_W-1:0]    wdata_two;
    logic [INDEX_BITS-1:0] pair_one;
    logic [INDEX_BITS-1:0] pair_two;

    assign intervals.ready = (state_reg == ioj_pkg::ST_IDLE);
    assign accept          = intervals.valid && intervals.ready;
    assign out_free        = !out_valid_reg || pairs.ready;

    assign mc_eff = intervals.job_start ? '0 :
                    (intervals.from_first_set ? cnt_one_reg : cnt_two_reg);
    assign oc_eff = intervals.job_start ? '0 :
                    (intervals.from_first_set ? cnt_two_reg : cnt_one_reg);
    assign app_ok = mc_eff < CNT_W'(WINDOW_DEPTH);

    assign entry     = first_reg ? rd_two : rd_one;
    assign ent_start = entry[ENTRY_W-1 -: PB];
    assign ent_stop  = entry[ENTRY_W-PB-1 -: PB];
    assign ent_idx   = entry[INDEX_BITS-1:0];

    ioj_overlap_unit u_cmp (
        .entry_start (ent_start),
        .entry_stop  (ent_stop),
        .probe_start (st_reg),
        .probe_stop  (sp_reg),
        .res         (cmp)
    );

    assign hit        = cmp.keep && cmp.overlap && (n_reg < N_W'(ioj_pkg::RESULT_LIMIT));
    assign scan_stall = hit && held_valid_reg && !out_free;
    assign advance    = (state_reg == ioj_pkg::ST_SCAN) && !scan_stall;
    assign r_inc      = r_reg + 1'b1;
    assign last_entry = (r_inc == len_reg);
    assign pair_one   = first_reg ? idx_reg : ent_idx;
    assign pair_two   = first_reg ? ent_idx : idx_reg;

    // read the next entry early so its data is in the registered RAM output when the scan reaches it
    always_comb
    begin
        if (accept)
        begin
            raddr = '0;
        end
        else if (advance)
        begin
            raddr = r_inc[ADDR_W-1:0];
        end
        else
        begin
            raddr = r_reg[ADDR_W-1:0];
        end
    end

    // append to own window on accept, compact the other window during scan
    assign app_data = {intervals.interval_start, intervals.interval_stop,
                       intervals.interval_index};

    always_comb
    begin
        we_one    = 1'b0;
        we_two    = 1'b0;
        waddr_one = w_reg[ADDR_W-1:0];
        waddr_two = w_reg[ADDR_W-1:0];
        wdata_one = entry;
        wdata_two = entry;
        if (accept)
        begin
            if (intervals.from_first_set)
            begin
                we_one    = app_ok;
                waddr_one = mc_eff[ADDR_W-1:0];
                wdata_one = app_data;
            end
            else
            begin
                we_two    = app_ok;
                waddr_two = mc_eff[ADDR_W-1:0];
                wdata_two = app_data;
            end
        end
        else if (advance && cmp.keep)
        begin
            we_one = !first_reg;
            we_two = first_reg;
        end
    end

    ioj_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_one (
        .clk   (clk),
        .we    (we_one),
        .waddr (waddr_one),
        .wdata (wdata_one),
        .raddr (raddr),
        .rdata (rd_one)
    );

    ioj_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_win_two (
        .clk   (clk),
        .we    (we_two),
        .waddr (waddr_two),
        .wdata (wdata_two),
        .raddr (raddr),
        .rdata (rd_two)
    );

    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        st_next         = st_reg;
        sp_next         = sp_reg;
        idx_next        = idx_reg;
        ovf_next        = ovf_reg;
        len_next        = len_reg;
        r_next          = r_reg;
        w_next          = w_reg;
        n_next          = n_reg;
        held_valid_next = held_valid_reg;
        held_one_next   = held_one_reg;
        held_two_next   = held_two_reg;
        cnt_one_next    = cnt_one_reg;
        cnt_two_next    = cnt_two_reg;
        out_valid_next  = out_valid_reg && !pairs.ready;
        out_pair_next   = out_pair_reg;
        out_one_next    = out_one_reg;
        out_two_next    = out_two_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ioj_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    first_next      = intervals.from_first_set;
                    st_next         = intervals.interval_start;
                    sp_next         = intervals.interval_stop;
                    idx_next        = intervals.interval_index;
                    ovf_next        = !app_ok;
                    len_next        = oc_eff;
                    r_next          = '0;
                    w_next          = '0;
                    n_next          = '0;
                    held_valid_next = 1'b0;
                    if (intervals.job_start)
                    begin
                        cnt_one_next = '0;
                        cnt_two_next = '0;
                    end
                    if (app_ok)
                    begin
                        if (intervals.from_first_set)
                        begin
                            cnt_one_next = mc_eff + 1'b1;
                        end
                        else
                        begin
                            cnt_two_next = mc_eff + 1'b1;
                        end
                    end
                    state_next = (oc_eff == '0) ? ioj_pkg::ST_FLUSH : ioj_pkg::ST_SCAN;
                end
            end
            ioj_pkg::ST_SCAN:
            begin
                if (advance)
                begin
                    r_next = r_inc;
                    if (cmp.keep)
                    begin
                        w_next = w_reg + 1'b1;
                    end
                    if (hit)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_pair_next  = 1'b1;
                            out_one_next   = held_one_reg;
                            out_two_next   = held_two_reg;
                            out_ovf_next   = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_one_next   = pair_one;
                        held_two_next   = pair_two;
                        n_next          = n_reg + 1'b1;
                    end
                    if (last_entry)
                    begin
                        if (first_reg)
                        begin
                            cnt_two_next = w_next;
                        end
                        else
                        begin
                            cnt_one_next = w_next;
                        end
                        state_next = ioj_pkg::ST_FLUSH;
                    end
                end
            end
            ioj_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pair_next  = held_valid_reg;
                    out_one_next   = held_valid_reg ? held_one_reg : '0;
                    out_two_next   = held_valid_reg ? held_two_reg : '0;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = 1'b1;
                    state_next     = ioj_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ioj_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ioj_pkg::ST_IDLE;
            cnt_one_reg    <= '0;
            cnt_two_reg    <= '0;
            out_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            n_reg          <= '0;
            r_reg          <= '0;
            w_reg          <= '0;
            len_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_one_reg    <= cnt_one_next;
            cnt_two_reg    <= cnt_two_next;
            out_valid_reg  <= out_valid_next;
            held_valid_reg <= held_valid_next;
            n_reg          <= n_next;
            r_reg          <= r_next;
            w_reg          <= w_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg     <= first_next;
        st_reg        <= st_next;
        sp_reg        <= sp_next;
        idx_reg       <= idx_next;
        ovf_reg       <= ovf_next;
        held_one_reg  <= held_one_next;
        held_two_reg  <= held_two_next;
        out_pair_reg  <= out_pair_next;
        out_one_reg   <= out_one_next;
        out_two_reg   <= out_two_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign pairs.valid            = out_valid_reg;
    assign pairs.pair_valid       = out_pair_reg;
    assign pairs.first_set_index  = out_one_reg;
    assign pairs.second_set_index = out_two_reg;
    assign pairs.window_overflow  = out_ovf_reg;
    assign pairs.last_result      = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_one_reg <= CNT_W'(WINDOW_DEPTH)) && (cnt_two_reg <= CNT_W'(WINDOW_DEPTH)))
        else $error("window count above depth");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ioj_pkg::ST_SCAN) |-> ((w_reg <= r_reg) && (r_reg < len_reg)))
        else $error("compaction pointer passed read pointer");

    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (n_reg <= N_W'(ioj_pkg::RESULT_LIMIT)) && (!held_valid_reg || (n_reg != '0)))
        else $error("pair count inconsistent");

    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ioj_pkg::ST_FLUSH) && out_free) |=> (out_valid_reg && out_last_reg))
        else $error("flush did not produce last result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ioj_pkg::ST_IDLE) |-> !accept)
        else $error("input taken while busy");

endmodule

`default_nettype wire
